[design/bapd_pkg.sv]
// Shared types, widths and codes for the block average peak detector.
package bapd_pkg;

  // Field and state widths
  localparam int SAMPLE_W  = 16;
  localparam int FW_W      = 7;
  localparam int THR_W     = 16;
  localparam int POS_W     = 32;
  localparam int TSUM_W    = 48;
  localparam int PPOS_W    = 33;
  localparam int CNT32_W   = 32;
  localparam int BLK_SUM_W = SAMPLE_W + FW_W;

  // Parameter defaults
  localparam int RING_DEPTH_DEF       = 10;
  localparam int MAX_FILTER_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH          = 2;

  // Peak rule constants
  localparam int NEAR_LIMIT    = 35;
  localparam int SPACING_LIMIT = 30;
  localparam int REPORT_OFFSET = 10;

  // Register reset values
  localparam logic [FW_W-1:0]  FW_RESET  = 7'd4;
  localparam logic [THR_W-1:0] THR_RESET = 16'd10;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_WIDTH   = 1'b0,
    CFG_PEAK_THRESHOLD = 1'b1
  } cfg_idx_e;

  // Stream layout
  localparam int IN_TDATA_W    = 16;
  localparam int OFS_BPOS      = SAMPLE_W;
  localparam int OFS_PPOS      = OFS_BPOS + POS_W;
  localparam int OFS_PVAL      = OFS_PPOS + PPOS_W;
  localparam int OFS_PSF       = OFS_PVAL + SAMPLE_W;
  localparam int OUT_PAYLOAD_W = OFS_PSF + CNT32_W;
  localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  // One completed block handed from front to back
  typedef struct packed {
    logic [BLK_SUM_W-1:0] block_sum;
    logic [FW_W-1:0]      width;
    logic [POS_W-1:0]     total_samples;
    logic [TSUM_W-1:0]    total_sum;
  } bapd_job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } bapd_qstat_t;

  // One result request
  typedef struct packed {
    logic [SAMPLE_W-1:0]      block_average;
    logic [POS_W-1:0]         block_position;
    logic                     peak_found;
    logic signed [PPOS_W-1:0] peak_position;
    logic [SAMPLE_W-1:0]      peak_value;
    logic [CNT32_W-1:0]       peaks_so_far;
  } bapd_result_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_WRITE,
    BK_SCAN,
    BK_MUL,
    BK_DECIDE
  } back_state_e;

endpackage

[design/block_average_peak_detector_unit.sv]
// Top level of the block average peak detector.
// Samples stream in on s_axis; one sample is taken per cycle while the block
// queue has room. Every filter_width samples form a block, and each block
// gives exactly one result on m_axis: its truncated mean, its centre position
// and, when a window peak is confirmed, the peak reported ten positions early.
// The back end runs each block through a 23-step bit-serial divider, one ring
// write, a scan of RING_DEPTH-1 ring entries, one multiply and one decision,
// which waits while an earlier result is still held on m_axis. A two-entry
// queue sits between front and back; the stream stalls while it is full. The
// ring is cleared by reset; no clearing pass is needed. Write configuration
// only while no block is in flight.
module block_average_peak_detector_unit #(
  parameter int RING_DEPTH       = bapd_pkg::RING_DEPTH_DEF,
  parameter int MAX_FILTER_WIDTH = bapd_pkg::MAX_FILTER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample requests
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bapd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] sample
  // Result requests
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] block_average, [47:16] block_position, [80:48] peak_position,
  // [96:81] peak_value, [128:97] peaks_so_far, [135:129] zero
  output logic [bapd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser,  // [0] peak_found
  // Configuration writes
  input  logic                             cfg_we_i,
  input  logic [bapd_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [bapd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import bapd_pkg::*;

  logic [FW_W-1:0]  filter_width_q;
  logic [THR_W-1:0] peak_threshold_q;

  bapd_job_t    job_push;
  bapd_job_t    job_head;
  bapd_qstat_t  qstat;
  bapd_result_t result;
  logic         push;
  logic         pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_width_q   <= FW_RESET;
      peak_threshold_q <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FILTER_WIDTH:   filter_width_q   <= cfg_wdata_i[FW_W-1:0];
        CFG_PEAK_THRESHOLD: peak_threshold_q <= cfg_wdata_i[THR_W-1:0];
        default: begin
          filter_width_q <= filter_width_q;
        end
      endcase
    end
  end

  bapd_front #(
    .MAX_FILTER_WIDTH(MAX_FILTER_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .sample_i      (s_axis_tdata[SAMPLE_W-1:0]),
    .filter_width_i(filter_width_q),
    .qstat_i       (qstat),
    .push_o        (push),
    .job_o         (job_push)
  );

  bapd_queue #(
    .WIDTH($bits(bapd_job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(job_push),
    .pop_i  (pop),
    .rdata_o(job_head),
    .qstat_o(qstat)
  );

  bapd_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .qstat_i         (qstat),
    .job_i           (job_head),
    .pop_o           (pop),
    .peak_threshold_i(peak_threshold_q),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .result_o        (result)
  );

  // Pack the result fields
  assign m_axis_tdata = {
    {(OUT_TDATA_W - OUT_PAYLOAD_W){1'b0}},
    result.peaks_so_far,
    result.peak_value,
    result.peak_position,
    result.block_position,
    result.block_average
  };
  assign m_axis_tuser = result.peak_found;

endmodule

[design/bapd_front.sv]
// Front end: accumulates samples into blocks and queues each finished block.
module bapd_front #(
  parameter int MAX_FILTER_WIDTH = bapd_pkg::MAX_FILTER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [bapd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [bapd_pkg::FW_W-1:0]     filter_width_i,
  input  bapd_pkg::bapd_qstat_t         qstat_i,
  output logic                          push_o,
  output bapd_pkg::bapd_job_t           job_o
);
  import bapd_pkg::*;

  localparam int WCLAMP = (MAX_FILTER_WIDTH > (2**FW_W) - 1) ? (2**FW_W) - 1 : MAX_FILTER_WIDTH;
  localparam int SUM_W  = SAMPLE_W + $clog2(WCLAMP);

  logic [SUM_W-1:0]  sum_q;
  logic [FW_W-1:0]   sib_q;
  logic [POS_W-1:0]  ts_q;
  logic [TSUM_W-1:0] tsum_q;

  logic [FW_W-1:0]   eff_w;
  logic [SUM_W-1:0]  sum_next;
  logic [FW_W-1:0]   sib_next;
  logic [POS_W-1:0]  ts_next;
  logic [TSUM_W-1:0] tsum_next;
  logic              accept;
  logic              block_end;

  // Clamp the configured width to the supported range
  always_comb begin
    if (filter_width_i == '0) begin
      eff_w = FW_W'(1);
    end else if (int'(filter_width_i) > WCLAMP) begin
      eff_w = FW_W'(WCLAMP);
    end else begin
      eff_w = filter_width_i;
    end
  end

  assign s_ready_o = !qstat_i.full;
  assign accept    = s_valid_i && s_ready_o;
  assign sum_next  = sum_q + SUM_W'(sample_i);
  assign sib_next  = sib_q + FW_W'(1);
  assign ts_next   = ts_q + POS_W'(1);
  assign tsum_next = tsum_q + TSUM_W'(sum_next);
  assign block_end = sib_next >= eff_w;

  // Hand the finished block to the back end
  assign push_o              = accept && block_end;
  assign job_o.block_sum     = BLK_SUM_W'(sum_next);
  assign job_o.width         = eff_w;
  assign job_o.total_samples = ts_next;
  assign job_o.total_sum     = tsum_next;

  // Advance the running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      sib_q  <= '0;
      ts_q   <= '0;
      tsum_q <= '0;
    end else if (accept) begin
      ts_q <= ts_next;
      if (block_end) begin
        sum_q  <= '0;
        sib_q  <= '0;
        tsum_q <= tsum_next;
      end else begin
        sum_q <= sum_next;
        sib_q <= sib_next;
      end
    end
  end

endmodule

[design/bapd_queue.sv]
// Short first-in first-out queue of block requests between front and back.
module bapd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bapd_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   wdata_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   rdata_o,
  output bapd_pkg::bapd_qstat_t qstat_o
);
  import bapd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign qstat_o.full  = cnt_q == CNT_W'(DEPTH);
  assign qstat_o.empty = cnt_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign rdata_o       = mem_q[rptr_q];

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[design/bapd_back.sv]
// Back end: divides the block sum, updates the ring, scans it and decides on peaks.
module bapd_back #(
  parameter int RING_DEPTH = bapd_pkg::RING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bapd_pkg::bapd_qstat_t      qstat_i,
  input  bapd_pkg::bapd_job_t        job_i,
  output logic                       pop_o,
  input  logic [bapd_pkg::THR_W-1:0] peak_threshold_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output bapd_pkg::bapd_result_t     result_o
);
  import bapd_pkg::*;

  localparam int RI_W   = $clog2(RING_DEPTH);
  localparam int STEP_W = $clog2(BLK_SUM_W);

  localparam logic signed [PPOS_W-1:0] NEAR_S  = PPOS_W'(NEAR_LIMIT);
  localparam logic signed [PPOS_W-1:0] SPACE_S = PPOS_W'(SPACING_LIMIT);

  back_state_e state_q, state_d;

  // Job latched from the queue
  logic [FW_W-1:0]      w_q;
  logic [POS_W-1:0]     ts_q;
  logic [TSUM_W-1:0]    tsum_q;
  logic [POS_W-1:0]     bpos_q;

  // Divider
  logic [FW_W-1:0]      rem_q;
  logic [BLK_SUM_W-1:0] quo_q;
  logic [STEP_W-1:0]    step_q;
  logic [FW_W:0]        trial;
  logic                 trial_ge;
  logic [FW_W:0]        trial_sub;

  // Ring and scan
  logic [SAMPLE_W-1:0]  ring_val_q [RING_DEPTH];
  logic [POS_W-1:0]     ring_pos_q [RING_DEPTH];
  logic [RI_W-1:0]      ring_idx_q;
  logic [RI_W-1:0]      scan_idx_q;
  logic [RI_W-1:0]      scan_cnt_q;
  logic [SAMPLE_W-1:0]  wmax_q;
  logic [POS_W-1:0]     wmp_q;

  // Peak tracking
  logic [SAMPLE_W-1:0]  cand_val_q;
  logic [POS_W-1:0]     cand_pos_q;
  logic [POS_W-1:0]     last_pos_q;
  logic [CNT32_W-1:0]   ptotal_q;
  logic [TSUM_W-1:0]    prod_a_q;
  logic [TSUM_W-1:0]    prod_b_q;

  // Output register
  logic                 out_valid_q;
  bapd_result_t         out_q;
  logic                 emit;

  logic signed [PPOS_W-1:0] dnear;
  logic signed [PPOS_W-1:0] dspace;
  logic [TSUM_W:0]          rhs;
  logic                     test;
  logic                     found;
  logic [CNT32_W-1:0]       ptotal_next;

  // One restoring division step
  assign trial     = {rem_q, quo_q[BLK_SUM_W-1]};
  assign trial_ge  = trial >= {1'b0, w_q};
  assign trial_sub = trial - {1'b0, w_q};

  // Peak decision
  assign dnear  = $signed({1'b0, wmp_q}) - $signed({1'b0, cand_pos_q});
  assign dspace = $signed({1'b0, wmp_q}) - $signed({1'b0, last_pos_q});
  assign rhs    = {1'b0, tsum_q} + {1'b0, prod_b_q};
  assign test   = (dnear < NEAR_S) && (wmax_q < cand_val_q) && (ts_q != '0) &&
                  ({1'b0, prod_a_q} > rhs);
  assign found       = test && (dspace > SPACE_S);
  assign ptotal_next = ptotal_q + CNT32_W'(found);

  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake controls
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_q == STEP_W'(BLK_SUM_W - 1)) begin
          state_d = BK_WRITE;
        end
      end
      BK_WRITE: begin
        state_d = BK_SCAN;
      end
      BK_SCAN: begin
        if (scan_cnt_q == RI_W'(RING_DEPTH - 2)) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        state_d = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (!out_valid_q || m_ready_i) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Datapath and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      ts_q        <= '0;
      tsum_q      <= '0;
      bpos_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      ring_val_q  <= '{default: '0};
      ring_pos_q  <= '{default: '0};
      ring_idx_q  <= '0;
      scan_idx_q  <= '0;
      scan_cnt_q  <= '0;
      wmax_q      <= '0;
      wmp_q       <= '0;
      cand_val_q  <= '0;
      cand_pos_q  <= '0;
      last_pos_q  <= '0;
      ptotal_q    <= '0;
      prod_a_q    <= '0;
      prod_b_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the output once taken, unless a new one replaces it
      if (out_valid_q && m_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          if (pop_o) begin
            w_q    <= job_i.width;
            ts_q   <= job_i.total_samples;
            tsum_q <= job_i.total_sum;
            bpos_q <= job_i.total_samples - POS_W'(job_i.width >> 1);
            rem_q  <= '0;
            quo_q  <= job_i.block_sum;
            step_q <= '0;
          end
        end
        BK_DIV: begin
          rem_q  <= trial_ge ? trial_sub[FW_W-1:0] : trial[FW_W-1:0];
          quo_q  <= {quo_q[BLK_SUM_W-2:0], trial_ge};
          step_q <= step_q + STEP_W'(1);
        end
        BK_WRITE: begin
          ring_val_q[ring_idx_q] <= quo_q[SAMPLE_W-1:0];
          ring_pos_q[ring_idx_q] <= bpos_q;
          scan_idx_q             <= ring_idx_q;
          scan_cnt_q             <= '0;
          wmax_q                 <= '0;
        end
        BK_SCAN: begin
          if (ring_val_q[scan_idx_q] > wmax_q) begin
            wmax_q <= ring_val_q[scan_idx_q];
            wmp_q  <= ring_pos_q[scan_idx_q];
          end
          scan_idx_q <= (scan_idx_q == RI_W'(RING_DEPTH - 1)) ? '0 : scan_idx_q + RI_W'(1);
          scan_cnt_q <= scan_cnt_q + RI_W'(1);
        end
        BK_MUL: begin
          prod_a_q <= TSUM_W'(wmax_q) * TSUM_W'(ts_q);
          prod_b_q <= TSUM_W'(peak_threshold_i) * TSUM_W'(ts_q);
        end
        BK_DECIDE: begin
          if (emit) begin
            if (!test) begin
              cand_val_q <= wmax_q;
              cand_pos_q <= wmp_q;
            end
            if (found) begin
              last_pos_q <= cand_pos_q;
            end
            ptotal_q   <= ptotal_next;
            ring_idx_q <= (ring_idx_q == RI_W'(RING_DEPTH - 1)) ? '0 : ring_idx_q + RI_W'(1);
            out_valid_q          <= 1'b1;
            out_q.block_average  <= quo_q[SAMPLE_W-1:0];
            out_q.block_position <= bpos_q;
            out_q.peak_found     <= found;
            out_q.peak_position  <= found ? ({1'b0, cand_pos_q} - PPOS_W'(REPORT_OFFSET)) : '0;
            out_q.peak_value     <= found ? cand_val_q : '0;
            out_q.peaks_so_far   <= ptotal_next;
          end
        end
        default: begin
          wmax_q <= wmax_q;
        end
      endcase
    end
  end

endmodule

[design/bapd_checker.sv]
// Port-level checks for the block average peak detector, bound to the top level.
module bapd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bapd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);
  import bapd_pkg::*;

  // Hold a stalled result
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Peak fields stay zero when no peak is reported
  a_no_peak_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OFS_PSF-1:OFS_PPOS] == '0)
    else $error("peak fields set without a peak");

  // A confirmed peak always exceeds the window maximum, so its value is nonzero
  a_peak_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[OFS_PSF-1:OFS_PVAL] != '0)
    else $error("confirmed peak with zero value");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W] == '0)
    else $error("padding bits set");

  // No result on the edge after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result shown after reset");

endmodule

bind block_average_peak_detector_unit bapd_checker u_bapd_checker (.*);
